/* hw/rtl/lcs_pkg.sv */
// Shared definitions for the LCS length engine.
// Command codes, field widths and default sizes; no dependencies.
`default_nettype none

package lcs_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int MAX_LEN_DEF     = 64;
  localparam int SYMBOL_BITS_DEF = 8;

  // Fixed widths of the port fields.
  localparam int CMD_W     = 2;
  localparam int SYM_IN_W  = 8;
  localparam int LEN_OUT_W = 7;

  // Command codes carried in the cmd field.
  localparam logic [CMD_W-1:0] CMD_APPEND_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE  = 2'd2;

  // Read strobes that the sweep sends to the string store.
  typedef struct packed {
    logic rd_a;
    logic rd_b;
  } str_rd_t;

endpackage

`default_nettype wire

/* hw/rtl/lcs_length_engine_top.sv */
// LCS length engine top level. Append words are taken while no compute is in progress.
// A compute word sweeps the table of the two strings, row by row (no rows if either
// string is empty): a row-start step per row, then one cell per cycle through the row
// memory. The input stalls from the accepted compute word until the result is handed
// on, and longer while the output register still holds a result not yet taken.
// Reset (synchronous) empties both strings; memories keep data.
`default_nettype none

module lcs_length_engine_top #(
  parameter int MAX_LEN     = lcs_pkg::MAX_LEN_DEF,
  parameter int SYMBOL_BITS = lcs_pkg::SYMBOL_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [lcs_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [lcs_pkg::SYM_IN_W-1:0]  in_symbol,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [lcs_pkg::LEN_OUT_W-1:0]      out_subsequence_length,
  output logic                               out_truncated
);
  import lcs_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]             state_r;
  logic [LW-1:0]          res_r;
  logic                   out_valid_r;
  logic [LEN_OUT_W-1:0]   out_len_r;
  logic                   out_trunc_r;

  logic                   accept, start, emit;
  str_rd_t                rd;
  logic [AW-1:0]          rd_a_addr, rd_b_addr;
  logic [SYMBOL_BITS-1:0] rd_a_data, rd_b_data;
  logic [LW-1:0]          len_a, len_b, sweep_res;
  logic                   overflow, sweep_done;

  // Input handshake: words are taken only while no compute is in progress.
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign start    = accept && (in_cmd == CMD_COMPUTE);
  assign emit     = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  // Control: compute, hold the result, hand it to the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: if (start)      state_r <= ST_BUSY;
        ST_BUSY: if (sweep_done) state_r <= ST_EMIT;
        ST_EMIT: if (emit)       state_r <= ST_IDLE;
        default:                 state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sweep_done) begin
      res_r <= sweep_res;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_len_r   <= LEN_OUT_W'(res_r);
      out_trunc_r <= overflow;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_subsequence_length = out_len_r;
  assign out_truncated          = out_trunc_r;

  lcs_str_store #(.MAX_LEN(MAX_LEN), .SYMBOL_BITS(SYMBOL_BITS)) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .app_en    (accept),
    .app_cmd   (in_cmd),
    .app_sym   (in_symbol),
    .clr       (emit),
    .rd        (rd),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data),
    .len_a     (len_a),
    .len_b     (len_b),
    .overflow  (overflow)
  );

  lcs_row_sweep #(.MAX_LEN(MAX_LEN), .SYMBOL_BITS(SYMBOL_BITS)) u_sweep (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .len_a     (len_a),
    .len_b     (len_b),
    .rd        (rd),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data),
    .done      (sweep_done),
    .result    (sweep_res)
  );

endmodule

`default_nettype wire

/* hw/rtl/lcs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// Read data holds its value while no read is issued; no dependencies.
`default_nettype none

module lcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lcs_str_store.sv */
// String store: two symbol memories with their fill counts and overflow flag.
// Uses lcs_pkg and lcs_ram.
`default_nettype none

module lcs_str_store #(
  parameter int MAX_LEN     = 64,
  parameter int SYMBOL_BITS = 8,
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  localparam int LW = $clog2(MAX_LEN + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         app_en,
  input  wire logic [lcs_pkg::CMD_W-1:0]    app_cmd,
  input  wire logic [lcs_pkg::SYM_IN_W-1:0] app_sym,
  input  wire logic                         clr,
  input  wire lcs_pkg::str_rd_t             rd,
  input  wire logic [AW-1:0]                rd_a_addr,
  input  wire logic [AW-1:0]                rd_b_addr,
  output logic      [SYMBOL_BITS-1:0]       rd_a_data,
  output logic      [SYMBOL_BITS-1:0]       rd_b_data,
  output logic      [LW-1:0]                len_a,
  output logic      [LW-1:0]                len_b,
  output logic                              overflow
);
  import lcs_pkg::*;

  logic [LW-1:0]          len_a_r, len_b_r;
  logic                   ovf_r;
  logic                   full_a, full_b;
  logic                   wr_a, wr_b;
  logic [SYMBOL_BITS-1:0] sym_keep;

  // An append lands only while its string has room.
  assign full_a   = (len_a_r == LW'(MAX_LEN));
  assign full_b   = (len_b_r == LW'(MAX_LEN));
  assign wr_a     = app_en && (app_cmd == CMD_APPEND_A) && !full_a;
  assign wr_b     = app_en && (app_cmd == CMD_APPEND_B) && !full_b;
  assign sym_keep = SYMBOL_BITS'(app_sym);

  // Fill counts and overflow flag; reset or the hand-off of a result clears all three.
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      len_a_r <= '0;
      len_b_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (wr_a) begin
        len_a_r <= len_a_r + 1'b1;
      end
      if (wr_b) begin
        len_b_r <= len_b_r + 1'b1;
      end
      if (app_en && ((app_cmd == CMD_APPEND_A && full_a) ||
                     (app_cmd == CMD_APPEND_B && full_b))) begin
        ovf_r <= 1'b1;
      end
    end
  end

  lcs_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_LEN)) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (len_a_r[AW-1:0]),
    .wr_data (sym_keep),
    .rd_en   (rd.rd_a),
    .rd_addr (rd_a_addr),
    .rd_data (rd_a_data)
  );

  lcs_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_LEN)) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (len_b_r[AW-1:0]),
    .wr_data (sym_keep),
    .rd_en   (rd.rd_b),
    .rd_addr (rd_b_addr),
    .rd_data (rd_b_data)
  );

  assign len_a    = len_a_r;
  assign len_b    = len_b_r;
  assign overflow = ovf_r;

endmodule

`default_nettype wire

/* hw/rtl/lcs_row_sweep.sv */
// Row sweep: walks the LCS recurrence one cell per cycle over a row memory.
// Uses lcs_pkg and lcs_ram; reads symbols from lcs_str_store.
`default_nettype none

module lcs_row_sweep #(
  parameter int MAX_LEN     = 64,
  parameter int SYMBOL_BITS = 8,
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  localparam int LW = $clog2(MAX_LEN + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [LW-1:0]          len_a,
  input  wire logic [LW-1:0]          len_b,
  output lcs_pkg::str_rd_t            rd,
  output logic      [AW-1:0]          rd_a_addr,
  output logic      [AW-1:0]          rd_b_addr,
  input  wire logic [SYMBOL_BITS-1:0] rd_a_data,
  input  wire logic [SYMBOL_BITS-1:0] rd_b_data,
  output logic                        done,
  output logic      [LW-1:0]          result
);
  import lcs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROW  = 3'd1;
  localparam logic [2:0] S_CELL = 3'd2;
  localparam logic [2:0] S_TAIL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]    state_r;
  logic [LW-1:0] i_r, j_r;
  logic          empty_r;

  // Cell stage: one cell whose reads are in flight.
  logic          s_vld_r;
  logic [LW-1:0] s_j_r;
  logic          s_first_col_r, s_first_row_r;
  logic [LW-1:0] left_r, diag_r;

  logic [LW-1:0] row_rd, up, left_in, diag_in, cell_val;
  logic          issue;

  assign issue = (state_r == S_CELL);

  // Sequencer: a row-start cycle fetches the first-string symbol and lets the
  // previous row's last write land before the new row reads the row memory.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      empty_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            i_r     <= '0;
            empty_r <= (len_a == '0) || (len_b == '0);
            state_r <= ((len_a == '0) || (len_b == '0)) ? S_DONE : S_ROW;
          end
        end
        S_ROW: begin
          j_r     <= LW'(1);
          state_r <= S_CELL;
        end
        S_CELL: begin
          if (j_r == len_b) begin
            i_r     <= i_r + 1'b1;
            state_r <= (LW'(i_r + 1'b1) == len_a) ? S_TAIL : S_ROW;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_TAIL: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Symbol reads for the string store.
  assign rd.rd_a    = (state_r == S_ROW);
  assign rd.rd_b    = issue;
  assign rd_a_addr  = i_r[AW-1:0];
  assign rd_b_addr  = AW'(j_r - 1'b1);

  // Cell stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else begin
      s_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s_j_r         <= j_r;
      s_first_col_r <= (j_r == LW'(1));
      s_first_row_r <= (i_r == '0);
    end
  end

  // Recurrence: the first row sees zeros above, the first column zeros left.
  assign up       = s_first_row_r ? '0 : row_rd;
  assign left_in  = s_first_col_r ? '0 : left_r;
  assign diag_in  = s_first_col_r ? '0 : diag_r;
  assign cell_val = (rd_a_data == rd_b_data) ? LW'(diag_in + 1'b1) :
                    ((up > left_in) ? up : left_in);

  always_ff @(posedge clk) begin
    if (s_vld_r) begin
      left_r <= cell_val;
      diag_r <= up;
    end
  end

  lcs_ram #(.WIDTH(LW), .DEPTH(MAX_LEN + 1)) u_row_ram (
    .clk     (clk),
    .wr_en   (s_vld_r),
    .wr_addr (s_j_r),
    .wr_data (cell_val),
    .rd_en   (issue),
    .rd_addr (j_r),
    .rd_data (row_rd)
  );

  // The last cell computed is the bottom-right corner of the table.
  assign done   = (state_r == S_DONE);
  assign result = empty_r ? '0 : left_r;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the LCS length engine.
// Loads symbol strings, asks for results and checks each word against its own
// software model. Depends only on lcs_pkg and lcs_length_engine_top.
`timescale 1ns / 100ps

module tb_top;
  import lcs_pkg::*;

  localparam int MAX_LEN      = MAX_LEN_DEF;
  localparam int RANDOM_WORDS = 1200;
  localparam int MIN_COMPUTES = 48;
  localparam int DRAIN_CYCLES = 50;
  localparam int CYCLE_LIMIT  = 400000;

  // The block ignores the fourth command code.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [LEN_OUT_W-1:0] length;
    logic                 truncated;
  } lcs_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_cmd;
  logic [SYM_IN_W-1:0]  in_symbol;
  logic                 out_valid;
  logic                 out_stall;
  logic [LEN_OUT_W-1:0] out_subsequence_length;
  logic                 out_truncated;

  // Model state: the two strings, their lengths and the dropped-symbol flag.
  logic [SYM_IN_W-1:0] model_str_a [0:MAX_LEN-1];
  logic [SYM_IN_W-1:0] model_str_b [0:MAX_LEN-1];
  int                  model_len_a;
  int                  model_len_b;
  logic                model_dropped;

  lcs_result_t expected_results [$];
  lcs_result_t head_result;

  int  mismatch_count;
  int  results_seen;
  int  words_sent;
  int  computes_sent;
  int  cycle_count;
  int  hold_off_request;
  int  hold_count;
  bit  quiet;

  lcs_length_engine_top i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_cmd                 (in_cmd),
    .in_symbol              (in_symbol),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_subsequence_length (out_subsequence_length),
    .out_truncated          (out_truncated)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Fill the LCS table one row at a time over a single row of scores.
  function automatic int lcs_table_score();
    int row [0:MAX_LEN];
    int diag;
    int up;
    int left;
    for (int j = 0; j <= MAX_LEN; j++) row[j] = 0;
    for (int i = 0; i < model_len_a; i++) begin
      diag = 0;
      for (int j = 1; j <= model_len_b; j++) begin
        up = row[j];
        if (model_str_a[i] == model_str_b[j-1]) begin
          row[j] = diag + 1;
        end else begin
          left = row[j-1];
          row[j] = (up > left) ? up : left;
        end
        diag = up;
      end
    end
    return row[model_len_b];
  endfunction

  // Apply one accepted word to the model; a compute queues its result.
  task automatic lcs_predict_word(input logic [CMD_W-1:0] cmd, input logic [SYM_IN_W-1:0] sym);
    lcs_result_t res;
    case (cmd)
      CMD_APPEND_A: begin
        if (model_len_a < MAX_LEN) begin
          model_str_a[model_len_a] = sym;
          model_len_a++;
        end else begin
          model_dropped = 1'b1;
        end
      end
      CMD_APPEND_B: begin
        if (model_len_b < MAX_LEN) begin
          model_str_b[model_len_b] = sym;
          model_len_b++;
        end else begin
          model_dropped = 1'b1;
        end
      end
      CMD_COMPUTE: begin
        res.length    = LEN_OUT_W'(lcs_table_score());
        res.truncated = model_dropped;
        expected_results.push_back(res);
        model_len_a   = 0;
        model_len_b   = 0;
        model_dropped = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  // Offer one word at the falling edge and hold it until accepted.
  // Called just after a falling edge; returns just after a falling edge once the word is taken.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SYM_IN_W-1:0] sym);
    if (!quiet && $urandom_range(0, 99) < 6) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    in_cmd    = cmd;
    in_symbol = sym;
    do @(posedge clk); while (in_stall);
    lcs_predict_word(cmd, sym);
    if (cmd != CMD_UNUSED) words_sent++;
    if (cmd == CMD_COMPUTE) computes_sent++;
    @(negedge clk);
  endtask

  function automatic logic [SYM_IN_W-1:0] pick_symbol(input int base, input int span);
    return SYM_IN_W'(base + $urandom_range(0, span - 1));
  endfunction

  // Result receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    out_stall = 1'b0;
    hold_count = 0;
    forever begin
      @(negedge clk);
      if (hold_off_request > 0) begin
        hold_count = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_count > 0) begin
        out_stall = 1'b1;
        hold_count--;
      end else begin
        out_stall = !quiet && ($urandom_range(0, 99) < 6);
      end
    end
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result word, length %0d truncated %0b",
                                  out_subsequence_length, out_truncated));
      end else begin
        head_result = expected_results.pop_front();
        if (out_subsequence_length !== head_result.length)
          report_mismatch($sformatf("subsequence_length %0d, expected %0d",
                                    out_subsequence_length, head_result.length));
        if (out_truncated !== head_result.truncated)
          report_mismatch($sformatf("truncated %0b, expected %0b",
                                    out_truncated, head_result.truncated));
      end
    end
  end

  // Load two strings in random interleaving, then ask for the result.
  task automatic send_pair(input int na, input int nb, input int base, input int span);
    int left_a;
    int left_b;
    left_a = na;
    left_b = nb;
    while (left_a > 0 || left_b > 0) begin
      if (left_b == 0 || (left_a > 0 && $urandom_range(0, 1) == 1)) begin
        send_word(CMD_APPEND_A, pick_symbol(base, span));
        left_a--;
      end else begin
        send_word(CMD_APPEND_B, pick_symbol(base, span));
        left_b--;
      end
    end
    send_word(CMD_COMPUTE, pick_symbol(0, 256));
  endtask

  // Empty strings give a zero length: both strings empty, then only the second one empty.
  task automatic test_empty_strings();
    send_word(CMD_COMPUTE, 8'hFF);
    send_word(CMD_APPEND_A, 8'h00);
    send_word(CMD_APPEND_A, 8'hFF);
    send_word(CMD_COMPUTE, 8'h00);
  endtask

  // Extreme symbol values, with and without a match.
  task automatic test_symbol_extremes();
    send_word(CMD_APPEND_A, 8'hFF);
    send_word(CMD_APPEND_A, 8'h00);
    send_word(CMD_APPEND_A, 8'h07);
    send_word(CMD_APPEND_B, 8'h00);
    send_word(CMD_APPEND_B, 8'h07);
    send_word(CMD_APPEND_B, 8'hFF);
    send_word(CMD_COMPUTE, 8'h00);
    send_word(CMD_APPEND_A, 8'h00);
    send_word(CMD_APPEND_B, 8'hFF);
    send_word(CMD_COMPUTE, 8'hFF);
  endtask

  // The unused command code must leave the strings alone.
  task automatic test_unused_command();
    send_word(CMD_APPEND_A, 8'h05);
    send_word(CMD_UNUSED, 8'hFF);
    send_word(CMD_APPEND_B, 8'h05);
    send_word(CMD_UNUSED, 8'h00);
    send_word(CMD_COMPUTE, 8'h00);
  endtask

  // Hold the result side off while computes keep coming, so the input stalls.
  task automatic test_output_hold_off();
    hold_off_request = 300;
    repeat (5) send_pair($urandom_range(1, 4), $urandom_range(1, 4), 0, 3);
  endtask

  // Mostly well-formed load/compute sequences, some noise and broken ones.
  task automatic test_random_words();
    int seq_idx;
    int kind;
    int count;
    seq_idx = 0;
    words_sent = 0;
    computes_sent = 0;
    while (words_sent < RANDOM_WORDS || computes_sent < MIN_COMPUTES) begin
      quiet = (seq_idx >= 40 && seq_idx < 55);
      kind = $urandom_range(0, 99);
      if (seq_idx % 30 == 2) begin
        // Long strings around the capacity: drops and the largest results.
        send_pair($urandom_range(56, 70), $urandom_range(56, 70),
                  $urandom_range(0, 254), $urandom_range(1, 2));
      end else if (kind < 8) begin
        count = $urandom_range(1, 6);
        repeat (count) send_word(CMD_W'($urandom_range(0, 3)),
                                 SYM_IN_W'($urandom_range(0, 255)));
      end else if (kind < 12) begin
        send_pair($urandom_range(0, 3), 0, 0, 256);
      end else if (kind < 50) begin
        send_pair($urandom_range(0, 10), $urandom_range(0, 10), 0, $urandom_range(2, 4));
      end else if (kind < 70) begin
        send_pair($urandom_range(1, 10), $urandom_range(1, 10), 252, 4);
      end else begin
        send_pair($urandom_range(0, 10), $urandom_range(0, 10), 0, 256);
      end
      seq_idx++;
    end
    quiet = 1'b0;
  endtask

  // Test sequence.
  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_cmd           = CMD_APPEND_A;
    in_symbol        = '0;
    quiet            = 1'b0;
    hold_off_request = 0;
    mismatch_count   = 0;
    results_seen     = 0;
    words_sent       = 0;
    computes_sent    = 0;
    cycle_count      = 0;
    model_len_a      = 0;
    model_len_b      = 0;
    model_dropped    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_strings();
    test_symbol_extremes();
    test_unused_command();
    test_output_hold_off();
    test_random_words();
    in_valid = 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/lcs_pkg.sv
hw/rtl/lcs_ram.sv
hw/rtl/lcs_str_store.sv
hw/rtl/lcs_row_sweep.sv
hw/rtl/lcs_length_engine_top.sv
tb/tb_top.sv
